[src/lkv_pkg.sv]
// lkv_pkg: shared types and constants for the lru key/value cache
// depends on nothing; imported by the cell, the top level and the checker
`default_nettype none

package lkv_pkg;

    // default sizes of the store
    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // fixed widths of the stream fields
    localparam int OP_BITS          = 3;
    localparam int KEY_FIELD_BITS   = 32;
    localparam int VALUE_FIELD_BITS = 32;

    // entry limit register
    localparam int                    MAX_ENTRIES_BITS  = 5;
    localparam logic [MAX_ENTRIES_BITS-1:0] MAX_ENTRIES_RESET = 5'd16;

    // command codes
    typedef enum logic [OP_BITS-1:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_GET     = 3'd2,
        OP_TOUCH   = 3'd3,
        OP_DISCARD = 3'd4,
        OP_CLEAR   = 3'd5
    } lkv_op_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic    match;
        logic    update;
        lkv_op_t op;
        logic    any_hit;
    } lkv_ctrl_t;

endpackage

`default_nettype wire

[src/lkv_cell.sv]
// lkv_cell: one slot of the cache, holding key, value, valid bit and recency age
// depends on lkv_pkg; instantiated in a row by lru_key_value_cache_unit
`default_nettype none

module lkv_cell
    import lkv_pkg::*;
#(
    parameter int AGE_BITS   = $clog2(DEPTH_DEF),
    parameter int CNT_BITS   = $clog2(DEPTH_DEF + 1),
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire  lkv_ctrl_t       ctrl,
    input  wire  [KEY_BITS-1:0]   key_in,
    input  wire  [VALUE_BITS-1:0] value_in,
    input  wire  [AGE_BITS-1:0]   hit_age,
    input  wire  [AGE_BITS-1:0]   tail_age,
    input  wire  [CNT_BITS-1:0]   lim_m1,
    input  wire                   claim_in,
    output logic                  claim_out,
    output logic                  hit,
    output logic [AGE_BITS-1:0]   age,
    output logic [VALUE_BITS-1:0] value
);

    logic                  valid_reg, valid_next;
    logic [AGE_BITS-1:0]   age_reg, age_next;
    logic                  hit_reg, hit_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  load;

    logic                  older, newer;
    logic                  valid1, valid2;
    logic [AGE_BITS-1:0]   age1;
    logic                  claim;

    // compare against the broadcast key
    assign hit   = valid_reg && (key_reg == key_in);
    assign age   = age_reg;
    assign value = value_reg;

    assign older = valid_reg && (age_reg > hit_age);
    assign newer = valid_reg && (age_reg < hit_age);

    // add: drop an old copy of the key, then evict beyond the limit
    always_comb
    begin
        valid1 = valid_reg;
        age1   = age_reg;
        if (ctrl.any_hit)
        begin
            if (hit_reg)
            begin
                valid1 = 1'b0;
            end
            else if (older)
            begin
                age1 = age_reg - AGE_BITS'(1);
            end
        end
        valid2 = valid1 && (CNT_BITS'(age1) < lim_m1);
    end

    // free slot claim ripples along the row, lowest index wins
    assign claim     = !valid2 && !claim_in;
    assign claim_out = claim_in || !valid2;

    // next slot state
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        hit_next   = hit_reg;
        load       = 1'b0;
        if (ctrl.match)
        begin
            hit_next = hit;
        end
        if (ctrl.update)
        begin
            unique case (ctrl.op)
                OP_ADD:
                begin
                    if (claim)
                    begin
                        valid_next = 1'b1;
                        age_next   = '0;
                        load       = 1'b1;
                    end
                    else if (valid2)
                    begin
                        valid_next = 1'b1;
                        age_next   = age1 + AGE_BITS'(1);
                    end
                    else
                    begin
                        valid_next = 1'b0;
                        age_next   = '0;
                    end
                end
                OP_REMOVE:
                begin
                    if (ctrl.any_hit)
                    begin
                        if (hit_reg)
                        begin
                            valid_next = 1'b0;
                            age_next   = '0;
                        end
                        else if (older)
                        begin
                            age_next = age_reg - AGE_BITS'(1);
                        end
                    end
                end
                OP_GET, OP_TOUCH:
                begin
                    if (ctrl.any_hit)
                    begin
                        if (hit_reg)
                        begin
                            age_next = '0;
                        end
                        else if (newer)
                        begin
                            age_next = age_reg + AGE_BITS'(1);
                        end
                    end
                end
                OP_DISCARD:
                begin
                    if (ctrl.any_hit)
                    begin
                        if (hit_reg)
                        begin
                            age_next = tail_age;
                        end
                        else if (older)
                        begin
                            age_next = age_reg - AGE_BITS'(1);
                        end
                    end
                end
                OP_CLEAR:
                begin
                    valid_next = 1'b0;
                    age_next   = '0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // slot control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            hit_reg   <= hit_next;
        end
    end

    // slot payload, written on insert only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg   <= key_in;
            value_reg <= value_in;
        end
    end

endmodule

`default_nettype wire

[src/lru_key_value_cache_unit.sv]
// lru_key_value_cache_unit: fully associative key/value cache ordered by recency
// depends on lkv_pkg and lkv_cell; a row of DEPTH cells under a small sequencer
//
//  channel   direction  handshake                     content
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser op, tdata key and value
//  m_axis    out        m_axis_tvalid/m_axis_tready   tuser found, tdata read_value
//  cfg       in         cfg_wr_en                     cfg_wr_data max_entries
//
// every command passes a match state, where all cells compare the key and the hit
// age and value are collected, then an update state, where every cell applies its
// recency update; the next command is taken during that update state.
// the update cycle waits while a previous result still sits in the output register.
// reset empties the store at once and sets the entry limit to 16.
`default_nettype none

module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    // commands
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire  [63:0]                s_axis_tdata,   // key[31:0], value[63:32]
    input  wire  [OP_BITS-1:0]         s_axis_tuser,   // op[2:0]
    // results
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // read_value[31:0]
    output logic                       m_axis_tuser,   // found[0]
    // entry limit register
    input  wire                        cfg_wr_en,
    input  wire  [MAX_ENTRIES_BITS-1:0] cfg_wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > MAX_ENTRIES_BITS) ? CW : MAX_ENTRIES_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } state_t;

    state_t                state_reg;
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [31:0]           read_value_reg;

    lkv_op_t               op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  any_hit_reg;
    logic [AW-1:0]         hit_age_reg;
    logic [VALUE_BITS-1:0] hit_value_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [MAX_ENTRIES_BITS-1:0] max_entries_reg;

    logic                  accept;
    logic                  upd_go;
    lkv_ctrl_t             ctrl;

    logic [KEY_BITS+KEY_FIELD_BITS-1:0]     key_wide;
    logic [VALUE_BITS+VALUE_FIELD_BITS-1:0] value_wide;
    logic [VALUE_BITS+32-1:0]               rv_wide;

    logic [LW-1:0]         lim_raw, lim_eff;
    logic [CW-1:0]         lim_m1;
    logic [CW-1:0]         cnt_m1, cnt_add1, cnt_add2;
    logic [AW-1:0]         tail_age;

    logic                  cell_hit   [DEPTH];
    logic [AW-1:0]         cell_age   [DEPTH];
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic                  claim_in   [DEPTH];
    logic                  claim_out  [DEPTH];

    logic                  hit_any;
    logic [AW-1:0]         hit_age_or;
    logic [VALUE_BITS-1:0] hit_value_or;

    logic                  res_found;
    logic [31:0]           res_value;

    // handshakes
    assign upd_go        = (state_reg == ST_UPDATE) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE) || upd_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = read_value_reg;
    assign m_axis_tuser  = found_reg;

    // fit the stream fields to the stored widths
    assign key_wide   = {{KEY_BITS{1'b0}}, s_axis_tdata[KEY_FIELD_BITS-1:0]};
    assign value_wide = {{VALUE_BITS{1'b0}},
                         s_axis_tdata[KEY_FIELD_BITS+VALUE_FIELD_BITS-1:KEY_FIELD_BITS]};
    assign rv_wide    = {32'd0, hit_value_reg};

    // effective limit, clamped to 1..DEPTH
    assign lim_raw = LW'(max_entries_reg);
    always_comb
    begin
        priority if (lim_raw == '0)
        begin
            lim_eff = LW'(1);
        end
        else if (lim_raw > LW'(DEPTH))
        begin
            lim_eff = LW'(DEPTH);
        end
        else
        begin
            lim_eff = lim_raw;
        end
    end
    assign lim_m1 = CW'(lim_eff - LW'(1));

    // count arithmetic
    assign cnt_m1   = count_reg - CW'(1);
    assign tail_age = cnt_m1[AW-1:0];
    assign cnt_add1 = count_reg - CW'(any_hit_reg);
    assign cnt_add2 = (cnt_add1 > lim_m1) ? lim_m1 : cnt_add1;

    // cell control broadcast
    always_comb
    begin
        ctrl.match   = (state_reg == ST_MATCH);
        ctrl.update  = upd_go;
        ctrl.op      = op_reg;
        ctrl.any_hit = any_hit_reg;
    end

    // row of cells with the free slot claim chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign claim_in[i] = 1'b0;
        end
        else
        begin : g_next
            assign claim_in[i] = claim_out[i-1];
        end

        lkv_cell #(
            .AGE_BITS   (AW),
            .CNT_BITS   (CW),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .key_in    (key_reg),
            .value_in  (value_reg),
            .hit_age   (hit_age_reg),
            .tail_age  (tail_age),
            .lim_m1    (lim_m1),
            .claim_in  (claim_in[i]),
            .claim_out (claim_out[i]),
            .hit       (cell_hit[i]),
            .age       (cell_age[i]),
            .value     (cell_value[i])
        );
    end

    // collect the single hit across the row
    always_comb
    begin
        hit_any      = 1'b0;
        hit_age_or   = '0;
        hit_value_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_any      = hit_any | cell_hit[i];
            hit_age_or   = hit_age_or | (cell_hit[i] ? cell_age[i] : '0);
            hit_value_or = hit_value_or | (cell_hit[i] ? cell_value[i] : '0);
        end
    end

    // result and live count of the command in its update cycle
    always_comb
    begin
        res_found  = 1'b0;
        res_value  = '0;
        count_next = count_reg;
        unique case (op_reg)
            OP_ADD:
            begin
                res_found  = 1'b1;
                count_next = cnt_add2 + CW'(claim_out[DEPTH-1]);
            end
            OP_REMOVE:
            begin
                res_found = any_hit_reg;
                if (any_hit_reg)
                begin
                    count_next = cnt_m1;
                end
            end
            OP_GET:
            begin
                res_found = any_hit_reg;
                res_value = any_hit_reg ? rv_wide[31:0] : '0;
            end
            OP_TOUCH, OP_DISCARD:
            begin
                res_found = any_hit_reg;
            end
            OP_CLEAR:
            begin
                res_found  = 1'b1;
                count_next = '0;
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_MATCH;
                    end
                end
                ST_MATCH:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (upd_go)
                    begin
                        state_reg <= accept ? ST_MATCH : ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (upd_go)
            begin
                out_valid_reg  <= 1'b1;
                found_reg      <= res_found;
                read_value_reg <= res_value;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // live count, hit flag and entry limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            any_hit_reg     <= 1'b0;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            if (upd_go)
            begin
                count_reg <= count_next;
            end
            if (state_reg == ST_MATCH)
            begin
                any_hit_reg <= hit_any;
            end
            if (cfg_wr_en)
            begin
                max_entries_reg <= cfg_wr_data;
            end
        end
    end

    // command and hit payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= lkv_op_t'(s_axis_tuser);
            key_reg   <= key_wide[KEY_BITS-1:0];
            value_reg <= value_wide[VALUE_BITS-1:0];
        end
        if (state_reg == ST_MATCH)
        begin
            hit_age_reg   <= hit_age_or;
            hit_value_reg <= hit_value_or;
        end
    end

endmodule

`default_nettype wire

[src/lkv_checker.sv]
// lkv_checker: port level checks of the lru key/value cache, bound to the top level
// depends on lkv_pkg and lru_key_value_cache_unit
`default_nettype none

module lkv_checker
    import lkv_pkg::*;
(
    input wire                        clk,
    input wire                        rst_n,
    input wire                        s_axis_tvalid,
    input wire                        s_axis_tready,
    input wire                        m_axis_tvalid,
    input wire                        m_axis_tready,
    input wire [31:0]                 m_axis_tdata,
    input wire                        m_axis_tuser
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // a command beat is followed by its compare cycle, no back to back intake
    a_no_intake_after_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready
    ) else $error("command taken in the cycle after a command beat");

    // a miss never carries data
    a_miss_reads_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0)
    ) else $error("result without hit carries nonzero data");

    // a new result is registered once its command beat has passed the match and update states
    a_result_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_beat, 3)
    ) else $error("result appeared without a matching command beat");

    // stalled result holds
    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    ) else $error("stalled result changed");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[test/tb_lru_key_value_cache_unit.sv]
// tb_lru_key_value_cache_unit: self-checking bench for the lru key/value cache
// depends on lkv_pkg and lru_key_value_cache_unit; a built-in cache predictor
// checks every result beat against the command stream under random flow control
`timescale 1ns / 100ps

module tb_lru_key_value_cache_unit;
    import lkv_pkg::*;

    localparam int SLOTS       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 24;

    // op codes the block leaves unused
    localparam logic [OP_BITS-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic [31:0]        key;
        logic [31:0]        value;
    } cache_cmd_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
    } cache_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [63:0]                 s_axis_tdata = '0;   // key[31:0], value[63:32]
    logic [OP_BITS-1:0]          s_axis_tuser = '0;   // op[2:0]
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [31:0]                 m_axis_tdata;        // read_value[31:0]
    logic                        m_axis_tuser;        // found[0]
    logic                        cfg_wr_en = 1'b0;
    logic [MAX_ENTRIES_BITS-1:0] cfg_wr_data = '0;

    lru_key_value_cache_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // command stream and result bookkeeping
    cache_cmd_t    pending_cmds[$];
    cache_result_t expected_results[$];
    int            cmds_queued = 0;
    int            cmds_taken = 0;
    int            mismatches = 0;
    int            idle_cycles = 0;

    // shadow copy of the cache contents
    logic [31:0]                 shadow_key[SLOTS];
    logic [31:0]                 shadow_value[SLOTS];
    bit                          shadow_valid[SLOTS];
    int                          shadow_age[SLOTS];
    int                          shadow_count = 0;
    logic [MAX_ENTRIES_BITS-1:0] shadow_limit = MAX_ENTRIES_RESET;

    logic [31:0] key_pool[POOL_SIZE];

    // delete one live entry and close the gap in the recency order
    function automatic void drop_entry(int s);
        int i;
        int a;
        a = shadow_age[s];
        shadow_valid[s] = 1'b0;
        shadow_age[s] = 0;
        for (i = 0; i < SLOTS; i++)
            if (shadow_valid[i] && shadow_age[i] > a)
                shadow_age[i]--;
        if (shadow_count > 0)
            shadow_count--;
    endfunction

    // apply one command to the shadow cache and return the result it gives
    function automatic cache_result_t apply_cache_op(logic [OP_BITS-1:0] op,
                                                     logic [31:0] key,
                                                     logic [31:0] value);
        cache_result_t r;
        int            i;
        int            hit;
        int            lim;
        int            victim;
        int            free_slot;
        int            a;
        r = '0;
        hit = -1;
        for (i = 0; i < SLOTS; i++)
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key)
                hit = i;
        case (op)
            OP_ADD:
            begin
                lim = shadow_limit;
                if (lim < 1)
                    lim = 1;
                if (lim > SLOTS)
                    lim = SLOTS;
                if (hit >= 0)
                    drop_entry(hit);
                // evict least recent entries until there is room
                while (shadow_count >= lim)
                begin
                    victim = -1;
                    for (i = 0; i < SLOTS; i++)
                        if (shadow_valid[i] && (victim < 0 || shadow_age[i] > shadow_age[victim]))
                            victim = i;
                    drop_entry(victim);
                end
                free_slot = -1;
                for (i = 0; i < SLOTS; i++)
                    if (free_slot < 0 && !shadow_valid[i])
                        free_slot = i;
                for (i = 0; i < SLOTS; i++)
                    if (shadow_valid[i])
                        shadow_age[i]++;
                shadow_valid[free_slot] = 1'b1;
                shadow_key[free_slot] = key;
                shadow_value[free_slot] = value;
                shadow_age[free_slot] = 0;
                shadow_count++;
                r.found = 1'b1;
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    drop_entry(hit);
                    r.found = 1'b1;
                end
            end
            OP_GET, OP_TOUCH:
            begin
                // move the hit to most recent
                if (hit >= 0)
                begin
                    a = shadow_age[hit];
                    for (i = 0; i < SLOTS; i++)
                        if (shadow_valid[i] && shadow_age[i] < a)
                            shadow_age[i]++;
                    shadow_age[hit] = 0;
                    r.found = 1'b1;
                    if (op == OP_GET)
                        r.read_value = shadow_value[hit];
                end
            end
            OP_DISCARD:
            begin
                // move the hit to least recent
                if (hit >= 0)
                begin
                    a = shadow_age[hit];
                    for (i = 0; i < SLOTS; i++)
                        if (shadow_valid[i] && shadow_age[i] > a)
                            shadow_age[i]--;
                    shadow_age[hit] = shadow_count - 1;
                    r.found = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    shadow_valid[i] = 1'b0;
                    shadow_age[i] = 0;
                end
                shadow_count = 0;
                r.found = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly pool keys so that hits, replacements and evictions are common
    function automatic cache_cmd_t random_cmd();
        cache_cmd_t c;
        int         r;
        c.key = ($urandom_range(99, 0) < 85) ? key_pool[$urandom_range(POOL_SIZE-1, 0)]
                                             : $urandom;
        c.value = $urandom;
        r = $urandom_range(99, 0);
        if (r < 36)
            c.op = OP_ADD;
        else if (r < 48)
            c.op = OP_REMOVE;
        else if (r < 68)
            c.op = OP_GET;
        else if (r < 78)
            c.op = OP_TOUCH;
        else if (r < 90)
            c.op = OP_DISCARD;
        else if (r < 92)
            c.op = OP_CLEAR;
        else if (r < 94)
            c.op = $urandom_range(1, 0) ? OP_UNUSED_7 : OP_UNUSED_6;
        else
            c.op = OP_GET;
        return c;
    endfunction

    task automatic push_cmd(logic [OP_BITS-1:0] op, logic [31:0] key, logic [31:0] value);
        pending_cmds.push_back('{op: op, key: key, value: value});
        cmds_queued++;
    endtask

    task automatic wait_idle();
        while (cmds_taken != cmds_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(int v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[MAX_ENTRIES_BITS-1:0];
        shadow_limit = v[MAX_ENTRIES_BITS-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // stimulus: directed checks first, then random phases over several limits
    initial
    begin
        int limit_plan[8];
        int p;
        int n;
        limit_plan = '{0, 31, 17, 1, 8, 16, 3, 12};
        for (n = 0; n < SLOTS; n++)
        begin
            shadow_valid[n] = 1'b0;
            shadow_age[n] = 0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, every op, misses, replacement, unused codes
        write_limit(16);
        push_cmd(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        push_cmd(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        push_cmd(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        push_cmd(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(OP_TOUCH, 32'h0000_0000, 32'h0);
        push_cmd(OP_DISCARD, 32'h0000_0000, 32'h0);
        push_cmd(OP_GET, 32'h1234_5678, 32'h0);
        push_cmd(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        push_cmd(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        push_cmd(OP_TOUCH, 32'hFFFF_FFFF, 32'h0);
        push_cmd(OP_DISCARD, 32'h1234_5678, 32'h0);
        push_cmd(OP_ADD, 32'h0000_0000, 32'h5A5A_A5A5);
        push_cmd(OP_GET, 32'h0000_0000, 32'h0);
        push_cmd(OP_UNUSED_6, 32'h0000_0000, 32'hFFFF_FFFF);
        push_cmd(OP_UNUSED_7, 32'h0000_0000, 32'hFFFF_FFFF);
        push_cmd(OP_CLEAR, 32'h0, 32'h0);
        push_cmd(OP_GET, 32'h0000_0000, 32'h0);

        // eviction at a small limit, with a discarded entry evicted first
        write_limit(2);
        push_cmd(OP_ADD, 32'hA000_0001, 32'h1111_1111);
        push_cmd(OP_ADD, 32'hB000_0002, 32'h2222_2222);
        push_cmd(OP_DISCARD, 32'hB000_0002, 32'h0);
        push_cmd(OP_ADD, 32'hC000_0003, 32'h3333_3333);
        push_cmd(OP_GET, 32'hA000_0001, 32'h0);
        push_cmd(OP_GET, 32'hB000_0002, 32'h0);
        push_cmd(OP_ADD, 32'hD000_0004, 32'h4444_4444);
        push_cmd(OP_GET, 32'hC000_0003, 32'h0);

        // random phases; the limit changes with the store still populated
        for (p = 0; p < 8; p++)
        begin
            write_limit(limit_plan[p]);
            for (n = 0; n < 134; n++)
            begin
                pending_cmds.push_back(random_cmd());
                cmds_queued++;
            end
        end

        wait_idle();
        repeat (5) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // command driver: bursts of random length separated by random gaps
    int         burst_left = 0;
    int         gap_left = 0;
    cache_cmd_t next_cmd;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                s_axis_tuser <= next_cmd.op;
                s_axis_tdata <= {next_cmd.value, next_cmd.key};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(24, 0);
                    gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver: segments of differing stall styles plus long hold-offs
    int rx_style = 0;
    int seg_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!long_hold_done && cmds_taken >= 300)
        begin
            // one long hold so the block backs up and stalls its input
            long_hold_done = 1'b1;
            hold_left = 120;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(999, 0) == 0)
        begin
            hold_left = $urandom_range(100, 40);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(80, 20);
                rx_style = $urandom_range(3, 0);
            end
            else
                seg_left--;
            case (rx_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(1, 0));
                2: m_axis_tready <= ($urandom_range(9, 0) != 0);
                default: m_axis_tready <= (seg_left % 4 != 0);
            endcase
        end
    end

    // monitor: predict on each command beat, check each result beat
    cache_result_t got;
    cache_result_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_wr_en)
                idle_cycles = 0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(apply_cache_op(s_axis_tuser, s_axis_tdata[31:0],
                                                          s_axis_tdata[63:32]));
                cmds_taken++;
                idle_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                got.found = m_axis_tuser;
                got.read_value = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: found %0b read_value 0x%08h",
                           got.found, got.read_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, got.found);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected 0x%08h, got 0x%08h",
                               want.read_value, got.read_value);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no beat moved for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
src/lkv_pkg.sv
src/lkv_cell.sv
src/lru_key_value_cache_unit.sv
src/lkv_checker.sv
test/tb_lru_key_value_cache_unit.sv
